@@ src/psfh_pkg.sv @@
// Shared types and constants of the PC sampling function histogram.
`timescale 1ns / 1ps
package psfh_pkg;

    localparam int TABLE_BITS_DEF  = 16;
    localparam int FUNC_DEPTH_DEF  = 16384;
    localparam int PROBE_LIMIT_DEF = 64;

    localparam logic [63:0] GOLDEN = 64'h9E3779B97F4A7C15;

    typedef enum logic [1:0] {
        M_LOAD   = 2'd0,
        M_SAMPLE = 2'd1,
        M_READ   = 2'd2,
        M_CLEAR  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_LOADED = 3'd0,
        ST_NEW    = 3'd1,
        ST_EXIST  = 3'd2,
        ST_DROP   = 3'd3,
        ST_READ   = 3'd4,
        ST_CLEAR  = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        CFG_BASE  = 2'd0,
        CFG_END   = 2'd1,
        CFG_COUNT = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        E_LOAD,
        E_SAMPLE,
        E_READ,
        E_CLEAR
    } t_emit;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_LOAD, S_WIN, S_SRD, S_SCMP, S_KEY,
        S_M0, S_M1, S_M2, S_M3, S_PRD, S_PCMP, S_SEMIT,
        S_RDRD, S_RDOUT, S_CLR, S_CLEMIT
    } t_state;

    typedef struct packed {
        logic [1:0]  mode;
        logic [13:0] entry_index;
        logic [31:0] entry_value;
        logic [63:0] sample_address;
        logic [15:0] slot_index;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] hist_key;
        logic [31:0] hist_count;
        logic [31:0] func_start;
        logic        is_external;
        logic [31:0] sample_total;
        logic [31:0] external_samples;
        logic [31:0] dropped_samples;
    } t_out;

    typedef struct packed {
        logic       cap;
        logic       load_wr;
        logic       win;
        logic       srch_upd;
        logic       key_sel;
        logic       mul_en;
        logic [1:0] mul_ph;
        logic       slot_init;
        logic       prb_upd;
        logic       rd_sel;
        logic       clr_wr;
        logic       emit;
        t_emit      emit_kind;
    } t_cmd;

    typedef struct packed {
        logic srch_done;
        logic prb_stop;
        logic clr_last;
    } t_stat;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

endpackage

@@ src/psfh_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module psfh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ src/psfh_ctrl.sv @@
// Controller state machine of the PC sampling function histogram.
`timescale 1ns / 1ps
module psfh_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [1:0]     i_mode,
    input  psfh_pkg::t_stat i_stat,
    output psfh_pkg::t_cmd  o_cmd,
    output logic           o_busy
);
    import psfh_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT:   if (i_stat.clr_last) n_state = S_IDLE;
            S_IDLE: begin
                if (i_start) begin
                    case (t_mode'(i_mode))
                        M_LOAD:   n_state = S_LOAD;
                        M_SAMPLE: n_state = S_WIN;
                        M_READ:   n_state = S_RDRD;
                        default:  n_state = S_CLR;
                    endcase
                end
            end
            S_LOAD:   n_state = S_IDLE;
            S_WIN:    n_state = S_SRD;
            S_SRD:    n_state = i_stat.srch_done ? S_KEY : S_SCMP;
            S_SCMP:   n_state = S_SRD;
            S_KEY:    n_state = S_M0;
            S_M0:     n_state = S_M1;
            S_M1:     n_state = S_M2;
            S_M2:     n_state = S_M3;
            S_M3:     n_state = S_PRD;
            S_PRD:    n_state = S_PCMP;
            S_PCMP:   n_state = i_stat.prb_stop ? S_SEMIT : S_PRD;
            S_SEMIT:  n_state = S_IDLE;
            S_RDRD:   n_state = S_RDOUT;
            S_RDOUT:  n_state = S_IDLE;
            S_CLR:    if (i_stat.clr_last) n_state = S_CLEMIT;
            S_CLEMIT: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.emit_kind = E_LOAD;
        o_busy = 1'b1;
        case (r_state)
            S_INIT:   o_cmd.clr_wr = 1'b1;
            S_IDLE: begin
                o_busy = 1'b0;
                o_cmd.cap = i_start;
            end
            S_LOAD: begin
                o_cmd.load_wr = 1'b1;
                o_cmd.emit = 1'b1;
                o_cmd.emit_kind = E_LOAD;
            end
            S_WIN:    o_cmd.win = 1'b1;
            S_SCMP:   o_cmd.srch_upd = 1'b1;
            S_KEY:    o_cmd.key_sel = 1'b1;
            S_M0: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_ph = 2'd0;
            end
            S_M1: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_ph = 2'd1;
            end
            S_M2: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_ph = 2'd2;
            end
            S_M3:     o_cmd.slot_init = 1'b1;
            S_PCMP:   o_cmd.prb_upd = 1'b1;
            S_SEMIT: begin
                o_cmd.emit = 1'b1;
                o_cmd.emit_kind = E_SAMPLE;
            end
            S_RDRD:   o_cmd.rd_sel = 1'b1;
            S_RDOUT: begin
                o_cmd.emit = 1'b1;
                o_cmd.emit_kind = E_READ;
            end
            S_CLR:    o_cmd.clr_wr = 1'b1;
            S_CLEMIT: begin
                o_cmd.emit = 1'b1;
                o_cmd.emit_kind = E_CLEAR;
            end
            default:  o_busy = 1'b1;
        endcase
    end
endmodule

@@ src/psfh_dp.sv @@
// Datapath: config, function-start search, hash, probing, counters, result.
`timescale 1ns / 1ps
module psfh_dp #(
    parameter int TABLE_BITS  = psfh_pkg::TABLE_BITS_DEF,
    parameter int FUNC_DEPTH  = psfh_pkg::FUNC_DEPTH_DEF,
    parameter int PROBE_LIMIT = psfh_pkg::PROBE_LIMIT_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  psfh_pkg::t_in   i_item,
    input  psfh_pkg::t_cmd  i_cmd,
    output psfh_pkg::t_stat o_stat,
    input  logic            i_cfg_valid,
    input  logic [1:0]      i_cfg_index,
    input  logic [63:0]     i_cfg_data,
    output logic            o_valid,
    output psfh_pkg::t_out  o_result
);
    import psfh_pkg::*;

    localparam int FA = $clog2(FUNC_DEPTH);
    localparam int CW = $clog2(FUNC_DEPTH + 1);
    localparam int PW = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;

    logic [63:0] r_base, r_end;
    logic [CW-1:0] r_fcount;
    t_in r_item;

    logic [31:0] r_off, r_fr;
    logic [CW-1:0] r_lo, r_hix;
    logic [63:0] r_key;
    logic [31:0] r_fstart;
    logic r_ext;
    logic [63:0] r_p0;
    logic [31:0] r_cross;
    logic [TABLE_BITS-1:0] r_slot, r_clr;
    logic [PW-1:0] r_probe;
    t_status r_status;
    logic [31:0] r_count;
    logic [31:0] r_total, r_extc, r_drop;

    // config
    logic [31:0] cfg_n;
    assign cfg_n = {17'd0, i_cfg_data[14:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_end <= '0;
            r_fcount <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_BASE:  r_base <= i_cfg_data;
                CFG_END:   r_end <= i_cfg_data;
                CFG_COUNT: r_fcount <= (cfg_n > 32'(FUNC_DEPTH)) ? CW'(FUNC_DEPTH)
                                                                 : CW'(cfg_n);
                default:   r_base <= r_base;
            endcase
        end
    end

    // function-start table
    logic [31:0] idx32;
    logic        f_we;
    logic [CW:0] mid_sum;
    logic [FA-1:0] mid;
    logic [31:0] f_rdata;

    assign idx32 = {18'd0, r_item.entry_index};
    assign f_we = i_cmd.load_wr && (idx32 < 32'(FUNC_DEPTH));
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hix} - (CW + 1)'(1);
    assign mid = mid_sum[FA:1];

    psfh_ram #(.WIDTH(32), .DEPTH(FUNC_DEPTH)) u_func (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (idx32[FA-1:0]),
        .i_wdata (r_item.entry_value),
        .i_raddr (mid),
        .o_rdata (f_rdata)
    );

    // slot tables
    logic [63:0] k_rdata;
    logic [31:0] c_rdata;
    logic        hit_empty, hit_match, probe_last, s_we;
    logic [TABLE_BITS-1:0] s_waddr, s_raddr;
    logic [63:0] k_wdata;
    logic [31:0] c_wdata, c_inc;

    assign hit_empty = (k_rdata == '0);
    assign hit_match = (k_rdata == r_key);
    assign probe_last = (r_probe == PW'(PROBE_LIMIT - 1));
    assign c_inc = sat_inc(c_rdata);
    assign s_we = i_cmd.clr_wr || (i_cmd.prb_upd && (hit_empty || hit_match));
    assign s_waddr = i_cmd.clr_wr ? r_clr : r_slot;
    assign s_raddr = i_cmd.rd_sel ? r_item.slot_index[TABLE_BITS-1:0] : r_slot;
    assign k_wdata = i_cmd.clr_wr ? '0 : r_key;
    assign c_wdata = i_cmd.clr_wr ? '0 : (hit_empty ? 32'd1 : c_inc);

    psfh_ram #(.WIDTH(64), .DEPTH(2 ** TABLE_BITS)) u_keys (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (k_wdata),
        .i_raddr (s_raddr),
        .o_rdata (k_rdata)
    );

    psfh_ram #(.WIDTH(32), .DEPTH(2 ** TABLE_BITS)) u_counts (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (c_wdata),
        .i_raddr (s_raddr),
        .o_rdata (c_rdata)
    );

    assign o_stat.srch_done = (r_lo >= r_hix);
    assign o_stat.prb_stop = hit_empty || hit_match || probe_last;
    assign o_stat.clr_last = (r_clr == '1);

    // shared 32x32 multiplier for the low 64 bits of key * golden
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [31:0] hsum;

    always_comb begin
        mul_a = r_key[31:0];
        mul_b = GOLDEN[31:0];
        case (i_cmd.mul_ph)
            2'd1:    mul_a = r_key[63:32];
            2'd2:    mul_b = GOLDEN[63:32];
            default: mul_a = r_key[31:0];
        endcase
    end
    assign prod = {32'd0, mul_a} * {32'd0, mul_b};
    assign hsum = r_p0[63:32] + r_cross;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_item <= i_item;
        end
        if (i_cmd.win) begin
            r_off <= 32'(r_item.sample_address - r_base);
            r_lo <= '0;
            r_hix <= (r_item.sample_address >= r_base && r_item.sample_address < r_end)
                     ? r_fcount : '0;
            r_fr <= '0;
        end
        if (i_cmd.srch_upd) begin
            if (f_rdata <= r_off) begin
                r_fr <= f_rdata;
                r_lo <= CW'(mid_sum[CW:1]) + CW'(1);
            end else begin
                r_hix <= CW'(mid_sum[CW:1]);
            end
        end
        if (i_cmd.key_sel) begin
            if (r_fr != '0) begin
                r_key <= {32'd0, r_fr};
                r_fstart <= r_fr;
                r_ext <= 1'b0;
            end else begin
                r_key <= r_item.sample_address | 64'd1;
                r_fstart <= '0;
                r_ext <= 1'b1;
            end
        end
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_ph)
                2'd0:    r_p0 <= prod;
                2'd1:    r_cross <= prod[31:0];
                default: r_cross <= r_cross + prod[31:0];
            endcase
        end
        if (i_cmd.slot_init) begin
            r_slot <= hsum[16 +: TABLE_BITS];
            r_probe <= '0;
        end
        if (i_cmd.prb_upd) begin
            if (hit_empty) begin
                r_status <= ST_NEW;
                r_count <= 32'd1;
            end else if (hit_match) begin
                r_status <= ST_EXIST;
                r_count <= c_inc;
            end else if (probe_last) begin
                r_status <= ST_DROP;
                r_count <= '0;
            end else begin
                r_slot <= r_slot + TABLE_BITS'(1);
                r_probe <= r_probe + PW'(1);
            end
        end
    end

    // clearing sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.cap) begin
            r_clr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr <= r_clr + TABLE_BITS'(1);
        end
    end

    // counters and result beat
    logic [31:0] n_total, n_extc, n_drop;
    t_out n_out;

    always_comb begin
        n_total = r_total;
        n_extc = r_extc;
        n_drop = r_drop;
        n_out = '0;
        case (i_cmd.emit_kind)
            E_LOAD:   n_out.status = ST_LOADED;
            E_SAMPLE: begin
                n_total = sat_inc(r_total);
                if (r_ext) n_extc = sat_inc(r_extc);
                if (r_status == ST_DROP) n_drop = sat_inc(r_drop);
                n_out.status = r_status;
                n_out.hist_key = r_key;
                n_out.hist_count = r_count;
                n_out.func_start = r_fstart;
                n_out.is_external = r_ext;
            end
            E_READ: begin
                n_out.status = ST_READ;
                n_out.hist_key = k_rdata;
                n_out.hist_count = c_rdata;
                n_out.is_external = k_rdata[0];
            end
            default: begin
                n_total = '0;
                n_extc = '0;
                n_drop = '0;
                n_out.status = ST_CLEAR;
            end
        endcase
        n_out.sample_total = n_total;
        n_out.external_samples = n_extc;
        n_out.dropped_samples = n_drop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_extc <= '0;
            r_drop <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit;
            if (i_cmd.emit) begin
                r_total <= n_total;
                r_extc <= n_extc;
                r_drop <= n_drop;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_result <= n_out;
        end
    end
endmodule

@@ src/pc_sample_function_histogram.sv @@
// Top level of the PC sampling function histogram.
`timescale 1ns / 1ps
// One command is taken when start is high and busy low; its result appears
// for one cycle with o_valid, and the receiver cannot stall it. A clear is a
// sweep of the slot RAMs, one slot per cycle. In a sample each binary-search
// step and each probe is one registered read of a RAM, and the hash multiply
// is three passes of one 32x32 multiplier. After reset the same sweep runs
// with busy high. Config writes are only taken while busy is low, so they
// never land in the middle of a command.
module pc_sample_function_histogram #(
    parameter int TABLE_BITS  = psfh_pkg::TABLE_BITS_DEF,
    parameter int FUNC_DEPTH  = psfh_pkg::FUNC_DEPTH_DEF,
    parameter int PROBE_LIMIT = psfh_pkg::PROBE_LIMIT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  psfh_pkg::t_in  i_item,
    output logic           o_valid,
    output psfh_pkg::t_out o_result,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [1:0]     i_cfg_index,
    input  logic [63:0]    i_cfg_data
);
    import psfh_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = !busy;

    psfh_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_mode  (i_item.mode),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    psfh_dp #(
        .TABLE_BITS  (TABLE_BITS),
        .FUNC_DEPTH  (FUNC_DEPTH),
        .PROBE_LIMIT (PROBE_LIMIT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );

`ifndef NO_ASSERTIONS
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result beat while busy");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("accepted command did not go busy");
    a_load_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.status == ST_LOADED |->
        o_result.hist_key == '0 && o_result.hist_count == '0)
        else $error("load result carries slot data");
    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.status == ST_DROP |-> o_result.hist_count == '0)
        else $error("dropped sample with nonzero count");
`endif
endmodule
